FILE: hdl/positional_array_list_assert.svh
// Assertion macros for the positional array list RTL.
// Used by the modules that carry concurrent checks; clocked on clk_i, reset by rst_ni.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be seen out of reset
`define PAL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PAL_ASSERT(lbl, prop, msg)
`define PAL_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/pal_pkg.sv
// Shared types and constants for the positional array list.
// No dependencies; imported by pal_ctrl and positional_array_list.
package pal_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned ActW  = 2;

  // action codes
  localparam logic [ActW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActW-1:0] ACT_DELETE = 2'd1;
  localparam logic [ActW-1:0] ACT_LOCATE = 2'd2;

  // one command transaction
  typedef struct packed {
    logic [ActW-1:0]         action;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] item_value;
  } pal_cmd_t;

  // one result transaction
  typedef struct packed {
    logic                    success;
    logic signed [DataW-1:0] removed_value;
    logic [PosW-1:0]         found_position;
    logic [PosW-1:0]         list_length;
  } pal_res_t;

endpackage

FILE: hdl/pal_mem.sv
// Entry store of the positional array list: one write port, one read port.
// Read data is registered. Uses no package.
module pal_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pal_ctrl.sv
// Sequencer of the positional array list: range checks, shift loops and the
// linear search, all through one shared index decrement and increment and one word compare.
// Depends on pal_pkg and the assertion macro header.
`include "positional_array_list_assert.svh"

module pal_ctrl #(
  parameter int unsigned Capacity = 8,
  localparam int unsigned CntW  = $clog2(Capacity + 1),
  localparam int unsigned AddrW = $clog2(Capacity)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  pal_pkg::pal_cmd_t     cmd_i,
  output logic                  busy_o,
  output logic                  fin_o,
  output pal_pkg::pal_res_t     res_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output logic [pal_pkg::DataW-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  logic [pal_pkg::DataW-1:0] mem_rdata_i
);
  import pal_pkg::*;

  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CmpW-1:0] CapW = CmpW'(Capacity);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_RD      = 4'd2;
  localparam logic [3:0] ST_INS_WR  = 4'd3;
  localparam logic [3:0] ST_INS_PUT = 4'd4;
  localparam logic [3:0] ST_DEL_RD0 = 4'd5;
  localparam logic [3:0] ST_DEL_CAP = 4'd6;
  localparam logic [3:0] ST_DEL_WR  = 4'd7;
  localparam logic [3:0] ST_LOC_CMP = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ok_q, ok_d;
  logic [PosW-1:0]  found_q, found_d;
  logic [DataW-1:0] removed_q, removed_d;

  logic [CmpW-1:0]  pos_w, cnt_w, idx_w;
  logic [CntW-1:0]  idx_dn, idx_up, raddr_sel;
  logic             ins_ok, del_ok, hit;
  logic             wr_phase;

  // widened operands for the range checks
  assign pos_w = CmpW'(cmd_i.position);
  assign cnt_w = CmpW'(count_q);
  assign idx_w = CmpW'(idx_q);

  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CmpW'(1)) && (cnt_w < CapW);
  assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);

  // shared index decrement and increment, and word compare
  assign idx_dn = idx_q - CntW'(1);
  assign idx_up = idx_q + CntW'(1);
  assign hit    = (mem_rdata_i == DataW'(cmd_i.item_value));

  // read address: the entry below for insert, above for delete, in place otherwise
  always_comb begin
    raddr_sel = idx_q;
    if (state_q == ST_RD) begin
      case (cmd_i.action)
        ACT_INSERT: raddr_sel = idx_dn;
        ACT_DELETE: raddr_sel = idx_up;
        default:    raddr_sel = idx_q;
      endcase
    end
  end

  assign mem_re_o    = (state_q == ST_RD) || (state_q == ST_DEL_RD0);
  assign mem_raddr_o = raddr_sel[AddrW-1:0];

  // write port: shifted words, or the new word at its position
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    case (state_q)
      ST_INS_WR, ST_DEL_WR: begin
        mem_we_o = 1'b1;
      end
      ST_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(pos_w - CmpW'(1));
        mem_wdata_o = DataW'(cmd_i.item_value);
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    ok_d      = ok_q;
    found_d   = found_q;
    removed_d = removed_q;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ok_d      = 1'b0;
        found_d   = '0;
        removed_d = '0;
        state_d   = ST_DONE;
        case (cmd_i.action)
          ACT_INSERT: begin
            if (ins_ok) begin
              idx_d   = count_q;
              state_d = (cnt_w >= pos_w) ? ST_RD : ST_INS_PUT;
            end
          end
          ACT_DELETE: begin
            if (del_ok) begin
              idx_d   = CntW'(pos_w - CmpW'(1));
              state_d = ST_DEL_RD0;
            end
          end
          ACT_LOCATE: begin
            if (count_q != '0) begin
              idx_d   = '0;
              state_d = ST_RD;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RD: begin
        case (cmd_i.action)
          ACT_INSERT: state_d = ST_INS_WR;
          ACT_DELETE: state_d = ST_DEL_WR;
          default:    state_d = ST_LOC_CMP;
        endcase
      end
      ST_INS_WR: begin
        idx_d   = idx_dn;
        state_d = (idx_w > pos_w) ? ST_RD : ST_INS_PUT;
      end
      ST_INS_PUT: begin
        count_d = count_q + CntW'(1);
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DEL_RD0: begin
        state_d = ST_DEL_CAP;
      end
      ST_DEL_CAP: begin
        removed_d = mem_rdata_i;
        ok_d      = 1'b1;
        if (idx_w + CmpW'(1) < cnt_w) begin
          state_d = ST_RD;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DEL_WR: begin
        idx_d = idx_up;
        if (idx_w + CmpW'(2) < cnt_w) begin
          state_d = ST_RD;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = ST_DONE;
        end
      end
      ST_LOC_CMP: begin
        if (hit) begin
          ok_d    = 1'b1;
          found_d = PosW'(idx_w + CmpW'(1));
          state_d = ST_DONE;
        end else if (idx_w + CmpW'(1) < cnt_w) begin
          idx_d   = idx_up;
          state_d = ST_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    ok_q      <= ok_d;
    found_q   <= found_d;
    removed_q <= removed_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign fin_o  = (state_q == ST_DONE);

  assign res_o.success        = ok_q;
  assign res_o.removed_value  = removed_q;
  assign res_o.found_position = found_q;
  assign res_o.list_length    = PosW'(count_q);

  // states that may write the store
  assign wr_phase = (state_q == ST_INS_WR) || (state_q == ST_INS_PUT) || (state_q == ST_DEL_WR);

  // checks
  `PAL_ASSERT_NEVER(a_cnt_bound, CmpW'(count_q) > CapW, "list length above capacity")
  `PAL_ASSERT(a_we_state, mem_we_o |-> wr_phase, "store written outside a shift or put")
  `PAL_ASSERT(a_idle_cnt, (state_q == ST_IDLE) |=> $stable(count_q), "length changed in idle")
  `PAL_ASSERT(a_done_idle, (state_q == ST_DONE) |=> (state_q == ST_IDLE), "done without idle")

endmodule

FILE: hdl/positional_array_list.sv
// Top level of the positional array list: command capture, result register,
// sequencer and entry store. Depends on pal_pkg, pal_ctrl and pal_mem.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------
//   command  | start / busy       | cmd_i  (pal_pkg::pal_cmd_t)
//   result   | done_o strobe      | res_o  (pal_pkg::pal_res_t)
//
// One transaction at a time; the store has one write port and a registered read port,
// so each shifted or searched entry takes a read state and then a write or compare
// state of the sequencer. done_o is registered from the sequencer's done state.
// Reset clears the length; entry contents are not cleared and are never read unwritten.
// Results are not back-pressured: done_o is high for exactly one cycle.
module positional_array_list #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pal_pkg::pal_cmd_t cmd_i,
  output logic              done_o,
  output pal_pkg::pal_res_t res_o
);
  import pal_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic             accept;
  logic             ctrl_busy, ctrl_fin;
  pal_cmd_t         cmd_q;
  pal_res_t         ctrl_res, res_q;
  logic             done_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  assign accept = start && !ctrl_busy;
  assign busy   = ctrl_busy;

  // hold the command for the length of the transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_fin) begin
      res_q <= ctrl_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  pal_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (accept),
    .cmd_i       (cmd_q),
    .busy_o      (ctrl_busy),
    .fin_o       (ctrl_fin),
    .res_o       (ctrl_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pal_mem #(
    .Depth (CAPACITY),
    .Width (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: dv/positional_array_list_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_array_list: directed and random list commands.
// Depends on pal_pkg and the positional_array_list RTL; predicts each result in place.
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int unsigned CAPACITY     = 8;
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 1100;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pal_cmd_t cmd_i;
  logic     done_o;
  pal_res_t res_o;

  // list contents as the block should hold them, position 1 first
  logic signed [DataW-1:0] list_contents[$];
  // results still owed by the block, in command order
  pal_res_t owed_results[$];
  pal_res_t owed_head;

  bit gaps_on;
  int n_errors;
  int n_checked;
  int n_rejected;
  int n_found;
  int max_length;
  int act_seen[4];
  int stall_run;

  always #5 clk_i = ~clk_i;

  positional_array_list #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // apply one command to the list copy and return the result it should give
  function automatic pal_res_t apply_list_cmd(pal_cmd_t c);
    pal_res_t r;
    int       len;
    int       pos;
    r   = '0;
    len = list_contents.size();
    pos = int'(c.position);
    case (c.action)
      ACT_INSERT: begin
        if (pos >= 1 && pos <= len + 1 && len < CAPACITY) begin
          list_contents.insert(pos - 1, c.item_value);
          r.success = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos >= 1 && pos <= len) begin
          r.removed_value = list_contents[pos - 1];
          list_contents.delete(pos - 1);
          r.success = 1'b1;
        end
      end
      ACT_LOCATE: begin
        for (int j = 0; j < len; j++) begin
          if (list_contents[j] == c.item_value) begin
            r.found_position = PosW'(j + 1);
            r.success        = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.list_length = PosW'(list_contents.size());
    return r;
  endfunction

  function automatic pal_cmd_t mk_cmd(logic [ActW-1:0] act, int pos, logic signed [31:0] val);
    pal_cmd_t c;
    c.action     = act;
    c.position   = PosW'(pos);
    c.item_value = val;
    return c;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // corner values, values already held (for duplicates), or anything
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: begin
        if (list_contents.size() != 0)
          return list_contents[$urandom_range(0, list_contents.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // drive one command, wait for it to be taken, record what it should return
  task automatic send_cmd(pal_cmd_t c);
    pal_res_t r;
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = apply_list_cmd(c);
    owed_results.push_back(r);
    act_seen[c.action]++;
    if (!r.success) n_rejected++;
    if (c.action == ACT_LOCATE && r.success) n_found++;
    if (list_contents.size() > max_length) max_length = list_contents.size();
    if (gaps_on) hold_off(rand_gap());
  endtask

  task automatic flag_mismatch(string what, logic [63:0] expv, logic [63:0] actv);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, expv, actv);
  endtask

  // result checker: each strobe must match the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (owed_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result with no command outstanding: %p", $time, res_o);
      end else begin
        owed_head = owed_results.pop_front();
        n_checked++;
        if (res_o.success !== owed_head.success)
          flag_mismatch("success", owed_head.success, res_o.success);
        if (res_o.removed_value !== owed_head.removed_value)
          flag_mismatch("removed_value", owed_head.removed_value, res_o.removed_value);
        if (res_o.found_position !== owed_head.found_position)
          flag_mismatch("found_position", owed_head.found_position, res_o.found_position);
        if (res_o.list_length !== owed_head.list_length)
          flag_mismatch("list_length", owed_head.list_length, res_o.list_length);
      end
    end
  end

  // watchdog: no transaction in either direction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      stall_run = 0;
    end else begin
      stall_run++;
      if (stall_run >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results owed",
                 $time, stall_run, owed_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // edge cases: empty list, bad positions, full list, duplicates, unused code
  task automatic test_directed_cases();
    gaps_on = 1'b1;
    send_cmd(mk_cmd(ACT_LOCATE, 0, 32'sd5));
    send_cmd(mk_cmd(ACT_DELETE, 1, 32'sd0));
    send_cmd(mk_cmd(ACT_INSERT, 0, 32'sd3));
    send_cmd(mk_cmd(ACT_INSERT, 2, 32'sd3));
    send_cmd(mk_cmd(ACT_INSERT, 1, 32'sh7fffffff));
    send_cmd(mk_cmd(ACT_INSERT, 2, 32'sh80000000));
    send_cmd(mk_cmd(ACT_INSERT, 1, 32'sd0));
    send_cmd(mk_cmd(ACT_INSERT, 2, -32'sd1));
    send_cmd(mk_cmd(ACT_INSERT, 15, 32'sd9));
    send_cmd(mk_cmd(ACT_LOCATE, 0, 32'sh80000000));
    send_cmd(mk_cmd(ACT_INSERT, 5, -32'sd1));
    send_cmd(mk_cmd(ACT_LOCATE, 15, -32'sd1));
    send_cmd(mk_cmd(ACT_INSERT, 3, 32'sd1));
    send_cmd(mk_cmd(ACT_INSERT, 7, 32'sd42));
    send_cmd(mk_cmd(ACT_INSERT, 1, 32'sd7));
    send_cmd(mk_cmd(ACT_INSERT, 1, 32'sd9));
    send_cmd(mk_cmd(ACT_INSERT, 9, 32'sd9));
    send_cmd(mk_cmd(ACT_LOCATE, 0, 32'sd42));
    send_cmd(mk_cmd(ACT_UNUSED, 15, -32'sd1));
    send_cmd(mk_cmd(ACT_DELETE, 9, 32'sd0));
    send_cmd(mk_cmd(ACT_DELETE, 0, 32'sd0));
    send_cmd(mk_cmd(ACT_DELETE, 8, 32'sd0));
    send_cmd(mk_cmd(ACT_DELETE, 1, 32'sd0));
    send_cmd(mk_cmd(ACT_DELETE, 3, 32'sd0));
    send_cmd(mk_cmd(ACT_LOCATE, 0, 32'sd12345));
  endtask

  // back-to-back: fill to capacity, search every entry, drain to empty
  task automatic test_fill_and_drain();
    gaps_on = 1'b0;
    repeat (4) begin
      while (list_contents.size() < CAPACITY)
        send_cmd(mk_cmd(ACT_INSERT, $urandom_range(1, list_contents.size() + 1), pick_value()));
      send_cmd(mk_cmd(ACT_INSERT, $urandom_range(1, CAPACITY + 1), pick_value()));
      for (int j = 0; j < CAPACITY; j++)
        send_cmd(mk_cmd(ACT_LOCATE, $urandom_range(0, 15), list_contents[j]));
      while (list_contents.size() != 0)
        send_cmd(mk_cmd(ACT_DELETE, $urandom_range(1, list_contents.size()), $urandom));
      send_cmd(mk_cmd(ACT_DELETE, $urandom_range(0, 15), $urandom));
    end
  endtask

  // random mix in blocks, each block leaning towards growth or shrinkage
  task automatic test_random_mix();
    pal_cmd_t c;
    int       ins_pct;
    int       sel;
    int       len;
    for (int blk = 0; blk < RANDOM_ITEMS / 50; blk++) begin
      ins_pct = $urandom_range(25, 75);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (50) begin
        sel = $urandom_range(0, 99);
        len = list_contents.size();
        c   = mk_cmd(ACT_LOCATE, $urandom_range(0, 15), pick_value());
        if (sel < 3) begin
          c.action = ACT_UNUSED;
        end else if (sel < 3 + ins_pct * 77 / 100) begin
          c.action = ACT_INSERT;
          if ($urandom_range(0, 99) < 85) c.position = PosW'($urandom_range(1, len + 1));
        end else if (sel < 80) begin
          c.action = ACT_DELETE;
          if (len != 0 && $urandom_range(0, 99) < 85)
            c.position = PosW'($urandom_range(1, len));
        end else if (len != 0 && $urandom_range(0, 99) < 65) begin
          c.item_value = list_contents[$urandom_range(0, len - 1)];
        end
        send_cmd(c);
      end
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    gaps_on = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_random_mix();

    // let the last results arrive, then watch for strays
    @(negedge clk_i);
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Commands: %0d insert, %0d delete, %0d locate, %0d unused code; %0d rejected",
             act_seen[ACT_INSERT], act_seen[ACT_DELETE], act_seen[ACT_LOCATE],
             act_seen[ACT_UNUSED], n_rejected);
    $display("Results checked: %0d, locate hits: %0d, longest list: %0d, errors: %0d",
             n_checked, n_found, max_length, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: positional_array_list.f
+incdir+hdl
hdl/pal_pkg.sv
hdl/pal_mem.sv
hdl/pal_ctrl.sv
hdl/positional_array_list.sv
dv/positional_array_list_tb.sv
